>>> sv/ed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the euclidean distance block.
// No dependencies; compiled first.
package ed_pkg;

   // fixed width of the result field on the response channel
   localparam int RESULT_BITS = 48;

   // control tag that travels alongside each vector's closing sum through the root chain
   typedef struct packed {
      logic valid;
      logic sat;
      logic take_root;
   } ed_tag_type;

endpackage
`default_nettype wire

>>> sv/ed_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Request channel: one element pair per request, valid/ready handshake.
// Standalone; no package needed.
interface ed_req_if #(parameter int DATA_BITS = 16);
   logic                        valid;
   logic                        ready;
   logic signed [DATA_BITS-1:0] first_value;
   logic signed [DATA_BITS-1:0] second_value;
   logic                        last;

   modport source (output valid, first_value, second_value, last, input ready);
   modport sink   (input valid, first_value, second_value, last, output ready);
endinterface
`default_nettype wire

>>> sv/ed_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Response channel: one distance result per vector, valid/ready handshake.
// Depends on ed_pkg for the result width.
interface ed_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ed_pkg::RESULT_BITS-1:0] result;
   logic                           saturated;

   modport source (output valid, result, saturated, input ready);
   modport sink   (input valid, result, saturated, output ready);
endinterface
`default_nettype wire

>>> sv/ed_accum.sv
`timescale 1ns / 1ps
`default_nettype none
// Square-of-difference stage and saturating running sum.
// Depends on ed_pkg for the tag type handed to the root chain.
module ed_accum #(
   parameter int DATA_BITS  = 16,
   parameter int ACCUM_BITS = 48
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output      logic                        in_ready,
   input  wire logic signed [DATA_BITS-1:0] in_first,
   input  wire logic signed [DATA_BITS-1:0] in_second,
   input  wire logic                        in_last,
   input  wire logic                        take_root,
   input  wire logic                        chain_ready,
   output      ed_pkg::ed_tag_type          feed_tag,
   output      logic [ACCUM_BITS-1:0]       feed_sum
);
   import ed_pkg::*;

   localparam int MAG_BITS = DATA_BITS + 1;
   localparam int SQ_BITS  = 2 * DATA_BITS + 1;
   localparam int SUM_BITS = ((SQ_BITS > ACCUM_BITS) ? SQ_BITS : ACCUM_BITS) + 1;
   localparam logic [SUM_BITS-1:0] SUM_MAX = SUM_BITS'({ACCUM_BITS{1'b1}});

   logic                    a_valid_ff, a_valid_in;
   logic [SQ_BITS-1:0]      a_sq_ff, a_sq_in;
   logic                    a_last_ff, a_last_in;
   logic [ACCUM_BITS-1:0]   sum_ff, sum_in;
   logic                    ovf_ff, ovf_in;

   logic signed [MAG_BITS-1:0] diff;
   logic [MAG_BITS-1:0]        mag;
   logic [2*MAG_BITS-1:0]      prod;
   logic [SUM_BITS-1:0]        wide_sum;
   logic                       sat_hit;
   logic [ACCUM_BITS-1:0]      sat_sum;
   logic                       a_go;

   always_comb begin
      diff = MAG_BITS'(in_second) - MAG_BITS'(in_first);
      mag  = diff[MAG_BITS-1] ? MAG_BITS'(-diff) : MAG_BITS'(diff);
      prod = mag * mag;
   end

   always_comb begin
      wide_sum = SUM_BITS'(sum_ff) + SUM_BITS'(a_sq_ff);
      sat_hit  = wide_sum > SUM_MAX;
      sat_sum  = sat_hit ? {ACCUM_BITS{1'b1}} : wide_sum[ACCUM_BITS-1:0];
   end

   // a final element waits here until the root chain can take it
   assign a_go     = a_valid_ff && (!a_last_ff || chain_ready);
   assign in_ready = !a_valid_ff || a_go;

   always_comb begin
      a_valid_in = a_valid_ff;
      a_sq_in    = a_sq_ff;
      a_last_in  = a_last_ff;
      if (in_ready) begin
         a_valid_in = in_valid;
         a_sq_in    = prod[SQ_BITS-1:0];
         a_last_in  = in_last;
      end
   end

   always_comb begin
      sum_in = sum_ff;
      ovf_in = ovf_ff;
      if (a_go) begin
         if (a_last_ff) begin
            sum_in = '0;
            ovf_in = 1'b0;
         end else begin
            sum_in = sat_sum;
            ovf_in = ovf_ff | sat_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         a_last_ff  <= 1'b0;
         sum_ff     <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         a_last_ff  <= a_last_in;
         sum_ff     <= sum_in;
         ovf_ff     <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      a_sq_ff <= a_sq_in;
   end

   always_comb begin
      feed_tag.valid     = a_valid_ff && a_last_ff;
      feed_tag.sat       = ovf_ff | sat_hit;
      feed_tag.take_root = take_root;
      feed_sum           = sat_sum;
   end

endmodule
`default_nettype wire

>>> sv/ed_root_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One cell of the square-root chain: resolves one root bit per cell.
// Depends on ed_pkg for the tag type.
module ed_root_cell #(
   parameter int ROOT_BITS  = 24,
   parameter int ACCUM_BITS = 48
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire ed_pkg::ed_tag_type       tag_i,
   input  wire logic [2*ROOT_BITS-1:0]   rad_i,
   input  wire logic [ROOT_BITS+1:0]     rem_i,
   input  wire logic [ROOT_BITS-1:0]     root_i,
   input  wire logic [ACCUM_BITS-1:0]    sum_i,
   output      ed_pkg::ed_tag_type       tag_o,
   output      logic [2*ROOT_BITS-1:0]   rad_o,
   output      logic [ROOT_BITS+1:0]     rem_o,
   output      logic [ROOT_BITS-1:0]     root_o,
   output      logic [ACCUM_BITS-1:0]    sum_o
);
   import ed_pkg::*;

   localparam int RAD_BITS = 2 * ROOT_BITS;

   ed_tag_type              tag_ff;
   logic [RAD_BITS-1:0]     rad_ff, rad_in;
   logic [ROOT_BITS+1:0]    rem_ff, rem_in;
   logic [ROOT_BITS-1:0]    root_ff, root_in;
   logic [ACCUM_BITS-1:0]   sum_ff;

   logic [ROOT_BITS+1:0]    rem_sh;
   logic [ROOT_BITS+1:0]    trial;
   logic                    fits;

   // bring down the next two radicand bits and try root*4+1
   always_comb begin
      rem_sh  = {rem_i[ROOT_BITS-1:0], rad_i[RAD_BITS-1 -: 2]};
      trial   = {root_i, 2'b01};
      fits    = rem_sh >= trial;
      rem_in  = fits ? rem_sh - trial : rem_sh;
      root_in = {root_i[ROOT_BITS-2:0], fits};
      rad_in  = {rad_i[RAD_BITS-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= tag_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         sum_ff  <= sum_i;
      end
   end

   assign tag_o  = tag_ff;
   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign sum_o  = sum_ff;

endmodule
`default_nettype wire

>>> sv/euclidean_distance.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming euclidean distance / L2 norm.
// req_ch carries one element pair per request; the squared difference is added
// to a running sum that saturates at all ones in ACCUM_BITS and flags it. A
// request with last set closes the vector and yields one response on rsp_ch:
// the sum, or floor(sqrt(sum)) when the csr bit take_root is set (reset 1).
// For a norm, drive second_value with zero. csr_we/csr_wdata write take_root;
// change it only while no vector is in flight.
// Throughput: one request per cycle, including back-to-back vectors.
// The last request passes through the square stage register, the chain of root
// cells, one root bit per cell, and the output register before its response
// appears on rsp_ch.
// A stalled rsp_ch lets the chain fill; only a last request that finds the
// chain full holds off req_ch. Synchronous reset empties the pipeline, clears
// the sum and the flag, and sets take_root.
module euclidean_distance #(
   parameter int DATA_BITS  = 16,
   parameter int ACCUM_BITS = 48
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ed_req_if.sink     req_ch,
   ed_rsp_if.source   rsp_ch,
   input  wire logic  csr_we,
   input  wire logic  csr_wdata
);
   import ed_pkg::*;

   localparam int ROOT_BITS = (ACCUM_BITS + 1) / 2;
   localparam int RAD_BITS  = 2 * ROOT_BITS;

   logic                     take_root_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RESULT_BITS-1:0]   rsp_result_ff;
   logic                     rsp_sat_ff;

   ed_tag_type               tag_q  [0:ROOT_BITS];
   logic [RAD_BITS-1:0]      rad_q  [0:ROOT_BITS];
   logic [ROOT_BITS+1:0]     rem_q  [0:ROOT_BITS];
   logic [ROOT_BITS-1:0]     root_q [0:ROOT_BITS];
   logic [ACCUM_BITS-1:0]    sum_q  [0:ROOT_BITS];
   logic [ROOT_BITS:0]       adv;
   logic                     out_free;
   logic [ACCUM_BITS-1:0]    feed_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         take_root_ff <= 1'b1;
      end else if (csr_we) begin
         take_root_ff <= csr_wdata;
      end
   end

   ed_accum #(
      .DATA_BITS  (DATA_BITS),
      .ACCUM_BITS (ACCUM_BITS)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_ch.valid),
      .in_ready    (req_ch.ready),
      .in_first    (req_ch.first_value),
      .in_second   (req_ch.second_value),
      .in_last     (req_ch.last),
      .take_root   (take_root_ff),
      .chain_ready (adv[0]),
      .feed_tag    (tag_q[0]),
      .feed_sum    (feed_sum)
   );

   assign sum_q[0]  = feed_sum;
   assign rad_q[0]  = RAD_BITS'(feed_sum);
   assign rem_q[0]  = '0;
   assign root_q[0] = '0;

   assign out_free       = !rsp_valid_ff || rsp_ch.ready;
   assign adv[ROOT_BITS] = out_free;

   for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
      // a cell moves when it is empty or its successor moves
      assign adv[i] = !tag_q[i+1].valid || adv[i+1];

      ed_root_cell #(
         .ROOT_BITS  (ROOT_BITS),
         .ACCUM_BITS (ACCUM_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (adv[i]),
         .tag_i   (tag_q[i]),
         .rad_i   (rad_q[i]),
         .rem_i   (rem_q[i]),
         .root_i  (root_q[i]),
         .sum_i   (sum_q[i]),
         .tag_o   (tag_q[i+1]),
         .rad_o   (rad_q[i+1]),
         .rem_o   (rem_q[i+1]),
         .root_o  (root_q[i+1]),
         .sum_o   (sum_q[i+1])
      );
   end

   assign rsp_valid_in = out_free ? tag_q[ROOT_BITS].valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && tag_q[ROOT_BITS].valid) begin
         rsp_result_ff <= tag_q[ROOT_BITS].take_root ? RESULT_BITS'(root_q[ROOT_BITS])
                                                     : RESULT_BITS'(sum_q[ROOT_BITS]);
         rsp_sat_ff    <= tag_q[ROOT_BITS].sat;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.result    = rsp_result_ff;
   assign rsp_ch.saturated = rsp_sat_ff;

endmodule
`default_nettype wire
